// ===== src/bpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types and constants for the box/plane penetration test core.
// ----------------------------------------------------------------------------
package bpp_pkg;

	localparam int NORM_W         = 16;
	localparam int COORD_W        = 32;
	localparam int TAG_W          = 8;
	localparam int DEPTH_W        = 32;
	localparam int PROD_W         = COORD_W + NORM_W;
	localparam int ACC_W          = PROD_W + 2;
	localparam int FRAC_SHIFT     = 15;
	localparam int PLANE_W        = 3 * NORM_W + COORD_W;
	localparam int SLOT_COUNT_DEF = 16;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TEST = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_ACC,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	// Control word for the shared multiply-accumulate unit.
	typedef struct packed {
		logic mul;
		logic init;
		logic add;
	} mac_ctrl_t;

endpackage

// ===== src/bpp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/bpp_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_mac
// Shared multiply-accumulate unit: one corner-by-normal product per cycle,
// accumulated onto the negated, scaled plane offset, with sign and depth readout.
// ----------------------------------------------------------------------------
module bpp_mac (
	input  logic                                clk,
	input  bpp_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [bpp_pkg::COORD_W-1:0] coord,
	input  logic signed [bpp_pkg::NORM_W-1:0]  norm,
	input  logic signed [bpp_pkg::COORD_W-1:0] offset,
	output logic                                hit,
	output logic [bpp_pkg::DEPTH_W-1:0]         depth
);
	import bpp_pkg::*;

	localparam int MAG_W = ACC_W - FRAC_SHIFT;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  off_ext;
	logic signed [ACC_W-1:0]  neg_acc;
	logic [MAG_W-1:0]         mag;

	// Offset in Q35.15 (15 fractional bits), so it lines up with the corner products.
	assign off_ext = {{(ACC_W - COORD_W - FRAC_SHIFT){offset[COORD_W-1]}},
		offset, {FRAC_SHIFT{1'b0}}};

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= coord * norm;
		end
		if (ctrl.init) begin
			acc_q <= -off_ext;
		end else if (ctrl.add) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	assign hit     = acc_q[ACC_W-1];
	assign neg_acc = -acc_q;
	assign mag     = neg_acc[ACC_W-1:FRAC_SHIFT];
	assign depth   = (|mag[MAG_W-1:DEPTH_W]) ? {DEPTH_W{1'b1}} : mag[DEPTH_W-1:0];

endmodule

// ===== src/box_plane_penetration_test_core.sv =====
`timescale 1ns / 1ps
// A plane load is accepted in idle, and the core stays ready for another request.
// A box test walks the stored planes in load order (with an empty table the core
// never leaves idle): one shared multiplier forms three products per plane,
// followed by accumulate and evaluate steps.
// One box is in flight at a time; events may stall on a busy output.
// Reset clears the plane count and all control state; the table needs no clear.
// ----------------------------------------------------------------------------
// box_plane_penetration_test_core
// Stores a table of planes and tests axis-aligned boxes against each plane,
// emitting one event per penetrated plane in load order.
// ----------------------------------------------------------------------------
module box_plane_penetration_test_core #(
	parameter int SLOT_COUNT = bpp_pkg::SLOT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic signed [bpp_pkg::NORM_W-1:0]  normal_x,
	input  logic signed [bpp_pkg::NORM_W-1:0]  normal_y,
	input  logic signed [bpp_pkg::NORM_W-1:0]  normal_z,
	input  logic signed [bpp_pkg::COORD_W-1:0] plane_offset,
	input  logic signed [bpp_pkg::COORD_W-1:0] box_min_x,
	input  logic signed [bpp_pkg::COORD_W-1:0] box_min_y,
	input  logic signed [bpp_pkg::COORD_W-1:0] box_min_z,
	input  logic signed [bpp_pkg::COORD_W-1:0] box_max_x,
	input  logic signed [bpp_pkg::COORD_W-1:0] box_max_y,
	input  logic signed [bpp_pkg::COORD_W-1:0] box_max_z,
	input  logic [bpp_pkg::TAG_W-1:0]           entity_tag,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bpp_pkg::TAG_W-1:0]           hit_tag,
	output logic signed [bpp_pkg::NORM_W-1:0]  hit_normal_x,
	output logic signed [bpp_pkg::NORM_W-1:0]  hit_normal_y,
	output logic signed [bpp_pkg::NORM_W-1:0]  hit_normal_z,
	output logic [bpp_pkg::DEPTH_W-1:0]         penetration,
	output logic                                last_hit
);
	import bpp_pkg::*;

	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_next;

	logic signed [COORD_W-1:0] min_x_q, min_y_q, min_z_q;
	logic signed [COORD_W-1:0] max_x_q, max_y_q, max_z_q;
	logic [TAG_W-1:0]          tag_q;

	logic [PLANE_W-1:0]       rdata;
	logic signed [NORM_W-1:0] nx, ny, nz;
	logic signed [COORD_W-1:0] noff;

	logic                  pend_valid_q;
	logic [NORM_W-1:0]     pend_nx_q, pend_ny_q, pend_nz_q;
	logic [DEPTH_W-1:0]    pend_depth_q;
	logic                  out_valid_q;

	logic                      accept_in;
	logic                      do_load;
	logic                      do_test;
	logic                      ram_re;
	logic [AW-1:0]             raddr;
	logic                      idx_clr;
	logic                      idx_inc;
	logic                      pend_store;
	logic                      pend_clr;
	logic                      out_push;
	logic                      out_last;
	logic                      can_push;
	mac_ctrl_t                 mac_ctrl;
	logic signed [COORD_W-1:0] mac_coord;
	logic signed [NORM_W-1:0]  mac_norm;
	logic                      mac_hit;
	logic [DEPTH_W-1:0]        mac_depth;

	assign accept_in = in_valid && in_ready;
	assign do_load   = accept_in && (func == FUNC_LOAD) && (count_q < CW'(SLOT_COUNT));
	assign do_test   = accept_in && (func == FUNC_TEST);
	assign idx_next  = idx_q + CW'(1);
	assign can_push  = !out_valid_q || out_ready;

	assign nx   = rdata[NORM_W-1:0];
	assign ny   = rdata[2*NORM_W-1:NORM_W];
	assign nz   = rdata[3*NORM_W-1:2*NORM_W];
	assign noff = rdata[PLANE_W-1:3*NORM_W];

	bpp_ram #(
		.WIDTH(PLANE_W),
		.DEPTH(SLOT_COUNT)
	) u_plane_ram (
		.clk  (clk),
		.we   (do_load),
		.waddr(count_q[AW-1:0]),
		.wdata({plane_offset, normal_z, normal_y, normal_x}),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Deepest corner: the min coordinate where the normal is strictly positive.
	always_comb begin
		mac_coord = max_x_q;
		mac_norm  = nx;
		case (state_q)
			ST_MX: begin
				mac_norm  = nx;
				mac_coord = (!nx[NORM_W-1] && (|nx)) ? min_x_q : max_x_q;
			end
			ST_MY: begin
				mac_norm  = ny;
				mac_coord = (!ny[NORM_W-1] && (|ny)) ? min_y_q : max_y_q;
			end
			ST_MZ: begin
				mac_norm  = nz;
				mac_coord = (!nz[NORM_W-1] && (|nz)) ? min_z_q : max_z_q;
			end
			default: begin
				mac_coord = max_x_q;
				mac_norm  = nx;
			end
		endcase
	end

	bpp_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.coord (mac_coord),
		.norm  (mac_norm),
		.offset(noff),
		.hit   (mac_hit),
		.depth (mac_depth)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		ram_re     = 1'b0;
		raddr      = '0;
		idx_clr    = 1'b0;
		idx_inc    = 1'b0;
		pend_store = 1'b0;
		pend_clr   = 1'b0;
		out_push   = 1'b0;
		out_last   = 1'b0;
		mac_ctrl   = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (do_test && (count_q != '0)) begin
					ram_re  = 1'b1;
					idx_clr = 1'b1;
					state_d = ST_MX;
				end
			end
			ST_MX: begin
				mac_ctrl.mul  = 1'b1;
				mac_ctrl.init = 1'b1;
				state_d       = ST_MY;
			end
			ST_MY: begin
				mac_ctrl.mul = 1'b1;
				mac_ctrl.add = 1'b1;
				state_d      = ST_MZ;
			end
			ST_MZ: begin
				mac_ctrl.mul = 1'b1;
				mac_ctrl.add = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				mac_ctrl.add = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				// A new hit releases the held one, which is then known not to be last.
				if (!(mac_hit && pend_valid_q && !can_push)) begin
					if (mac_hit) begin
						pend_store = 1'b1;
						out_push   = pend_valid_q;
					end
					if (idx_next < count_q) begin
						ram_re  = 1'b1;
						raddr   = idx_next[AW-1:0];
						idx_inc = 1'b1;
						state_d = ST_MX;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (can_push) begin
					out_push = 1'b1;
					out_last = 1'b1;
					pend_clr = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (do_load) begin
				count_q <= count_q + CW'(1);
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_next;
			end
			if (pend_store) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_test) begin
			min_x_q <= box_min_x;
			min_y_q <= box_min_y;
			min_z_q <= box_min_z;
			max_x_q <= box_max_x;
			max_y_q <= box_max_y;
			max_z_q <= box_max_z;
			tag_q   <= entity_tag;
		end
		if (pend_store) begin
			pend_nx_q    <= nx;
			pend_ny_q    <= ny;
			pend_nz_q    <= nz;
			pend_depth_q <= mac_depth;
		end
		if (out_push) begin
			hit_tag      <= tag_q;
			hit_normal_x <= pend_nx_q;
			hit_normal_y <= pend_ny_q;
			hit_normal_z <= pend_nz_q;
			penetration  <= pend_depth_q;
			last_hit     <= out_last;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOT_COUNT))
		else $error("plane count exceeds table capacity");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held event left behind after box test");

	a_not_last_has_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_hit) |-> pend_valid_q)
		else $error("non-final event shown without a following event held");

	a_empty_test: assert property (@(posedge clk) disable iff (!arst_n)
		(do_test && (count_q == '0)) |=> (state_q == ST_IDLE))
		else $error("box test with empty table did not return to idle");
`endif

endmodule
